// File: sv/ffe_pkg.sv
// ----------------------------------------------------------------------------
// ffe_pkg: shared types, constants and fixed-point helpers
// Q-format saturation, product rescaling and register codes for the FORCE
// flux pipeline.
// ----------------------------------------------------------------------------
package ffe_pkg;

   // data word, ratio register and gamma register widths
   localparam int DW     = 32;
   localparam int RW     = 31;
   localparam int GW     = 18;
   localparam int WW     = 2 * DW + 2;
   localparam int CSR_IW = 2;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_DT_OVER_DX = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_DX_OVER_DT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_GAMMA_M1   = 2'd2;

   // register reset values
   localparam logic [RW-1:0] RST_DT_OVER_DX = 31'd65536;
   localparam logic [RW-1:0] RST_DX_OVER_DT = 31'd65536;
   localparam logic [GW-1:0] RST_GAMMA_M1   = 18'd26214;

   localparam logic signed [DW-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;

   typedef logic signed [DW-1:0] word_type;

   // clamp a wide signed value to one data word
   function automatic word_type sat32(input logic signed [WW-1:0] x);
      word_type r;
      if (x > WW'(Q_MAX)) begin
         r = Q_MAX;
      end else if (x < WW'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = x[DW-1:0];
      end
      return r;
   endfunction

   // product back to Q format: floor shift, then clamp
   function automatic word_type qshift(input logic signed [2*DW-1:0] p,
                                       input int unsigned frac);
      logic signed [2*DW-1:0] s;
      s = p >>> frac;
      return sat32(WW'(s));
   endfunction

   // register stages of one physical flux unit
   function automatic int phys_lat(input int frac);
      return DW + frac + 10;
   endfunction

endpackage

// File: sv/ffe_delay.sv
// ----------------------------------------------------------------------------
// ffe_delay: fixed-length register delay line
// Keeps side data aligned with the physical flux units.
// ----------------------------------------------------------------------------
module ffe_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift line
   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// File: sv/ffe_phys.sv
// ----------------------------------------------------------------------------
// ffe_phys: pipelined physical flux of one conservative state
// Velocity by a one-bit-per-stage restoring divider, then pressure and
// the three flux terms over nine multiply and clamp stages.
// ----------------------------------------------------------------------------
module ffe_phys import ffe_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  word_type       rho,
   input  word_type       mom,
   input  word_type       ene,
   input  logic [GW-1:0]  gm1,
   output logic           out_valid,
   output word_type       f_mass,
   output word_type       f_mom,
   output word_type       f_ene,
   output logic           out_bad
);

   localparam int QW = DW + FRAC_BITS;

   // divider stage registers, index 0 is the entry stage
   logic          dvld_ff [QW+1];
   logic [QW-1:0] num_ff  [QW+1];
   logic [QW-1:0] quo_ff  [QW+1];
   logic [RW-1:0] rem_ff  [QW+1];
   logic [RW-1:0] den_ff  [QW+1];
   word_type      dmom_ff [QW+1];
   word_type      dene_ff [QW+1];
   logic          dbad_ff [QW+1];
   logic          dneg_ff [QW+1];

   logic [DW-1:0] mag_in;
   logic          bad_in;

   // entry: magnitude of momentum, divisor check
   always_comb begin
      mag_in = mom[DW-1] ? DW'(-mom) : DW'(mom);
      bad_in = rho[DW-1] | (rho == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff[0] <= 1'b0;
      end else begin
         dvld_ff[0] <= in_valid;
      end
      num_ff[0]  <= bad_in ? '0 : {mag_in, {FRAC_BITS{1'b0}}};
      den_ff[0]  <= bad_in ? RW'(1) : rho[RW-1:0];
      quo_ff[0]  <= '0;
      rem_ff[0]  <= '0;
      dmom_ff[0] <= mom;
      dene_ff[0] <= ene;
      dbad_ff[0] <= bad_in;
      dneg_ff[0] <= mom[DW-1];
   end

   // one quotient bit per stage
   for (genvar i = 1; i <= QW; i++) begin : g_div
      logic [DW-1:0] trial;
      logic          ge;
      logic [RW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[i-1], num_ff[i-1][QW-1]};
         ge     = trial >= {1'b0, den_ff[i-1]};
         rem_in = ge ? RW'(trial - {1'b0, den_ff[i-1]}) : trial[RW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[i] <= 1'b0;
         end else begin
            dvld_ff[i] <= dvld_ff[i-1];
         end
         rem_ff[i]  <= rem_in;
         num_ff[i]  <= {num_ff[i-1][QW-2:0], 1'b0};
         quo_ff[i]  <= {quo_ff[i-1][QW-2:0], ge};
         den_ff[i]  <= den_ff[i-1];
         dmom_ff[i] <= dmom_ff[i-1];
         dene_ff[i] <= dene_ff[i-1];
         dbad_ff[i] <= dbad_ff[i-1];
         dneg_ff[i] <= dneg_ff[i-1];
      end
   end

   // signed, clamped velocity
   logic [QW-1:0] quo;
   word_type      v_in;

   always_comb begin
      quo = quo_ff[QW];
      if (!dneg_ff[QW]) begin
         v_in = (|quo[QW-1:DW-1]) ? Q_MAX : quo[DW-1:0];
      end else if ((|quo[QW-1:DW]) || (quo[DW-1] && (|quo[DW-2:0]))) begin
         v_in = Q_MIN;
      end else begin
         v_in = DW'(-quo[DW-1:0]);
      end
   end

   // flux stages: 0 velocity, 1-2 m*v, 3 E-ke, 4-5 pressure,
   // 6 momentum flux and E+p, 7-8 energy flux
   logic                   pvld_ff [9];
   word_type               pmom_ff [9];
   logic                   pbad_ff [9];
   word_type               pene_ff [6];
   word_type               pv_ff   [7];
   word_type               mv_ff   [2:5];
   word_type               f1_ff   [6:8];
   logic signed [2*DW-1:0] mvp_ff;
   word_type               eke_ff;
   logic signed [2*DW-1:0] gp_ff;
   word_type               p_ff;
   word_type               epp_ff;
   logic signed [2*DW-1:0] ep_ff;
   word_type               f2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            pvld_ff[k] <= 1'b0;
         end
      end else begin
         pvld_ff[0] <= dvld_ff[QW];
         for (int k = 1; k < 9; k++) begin
            pvld_ff[k] <= pvld_ff[k-1];
         end
      end
      pmom_ff[0] <= dmom_ff[QW];
      pbad_ff[0] <= dbad_ff[QW];
      pene_ff[0] <= dene_ff[QW];
      pv_ff[0]   <= v_in;
      for (int k = 1; k < 9; k++) begin
         pmom_ff[k] <= pmom_ff[k-1];
         pbad_ff[k] <= pbad_ff[k-1];
      end
      for (int k = 1; k < 6; k++) begin
         pene_ff[k] <= pene_ff[k-1];
      end
      for (int k = 1; k < 7; k++) begin
         pv_ff[k] <= pv_ff[k-1];
      end
      mvp_ff   <= pmom_ff[0] * pv_ff[0];
      mv_ff[2] <= qshift(mvp_ff, FRAC_BITS);
      mv_ff[3] <= mv_ff[2];
      mv_ff[4] <= mv_ff[3];
      mv_ff[5] <= mv_ff[4];
      eke_ff   <= sat32(WW'(pene_ff[2]) - WW'(mv_ff[2] >>> 1));
      gp_ff    <= $signed({1'b0, gm1}) * eke_ff;
      p_ff     <= qshift(gp_ff, FRAC_BITS);
      f1_ff[6] <= sat32(WW'(mv_ff[5]) + WW'(p_ff));
      epp_ff   <= sat32(WW'(pene_ff[5]) + WW'(p_ff));
      f1_ff[7] <= f1_ff[6];
      f1_ff[8] <= f1_ff[7];
      ep_ff    <= epp_ff * pv_ff[6];
      f2_ff    <= qshift(ep_ff, FRAC_BITS);
   end

   assign out_valid = pvld_ff[8];
   assign f_mass    = pmom_ff[8];
   assign f_mom     = f1_ff[8];
   assign f_ene     = f2_ff;
   assign out_bad   = pbad_ff[8];

endmodule

// File: sv/force_flux_euler_1d_top.sv
// ----------------------------------------------------------------------------
// force_flux_euler_1d_top: FORCE flux for the 1D Euler equations
// Path: input register, left and right flux units, D1-D4, predictor flux
// unit and output register; each flux unit holds a divider chain of
// 32+FRAC_BITS stages.
// Throughput: one item per clock; busy is never raised.
// Reset: synchronous, clears all valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module force_flux_euler_1d_top import ffe_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  word_type          req_left_density,
   input  word_type          req_left_momentum,
   input  word_type          req_left_energy,
   input  word_type          req_right_density,
   input  word_type          req_right_momentum,
   input  word_type          req_right_energy,
   output logic              rsp_valid,
   output word_type          rsp_mass_flux,
   output word_type          rsp_momentum_flux,
   output word_type          rsp_energy_flux,
   output logic              rsp_invalid,
   input  logic              csr_write_enable,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [RW-1:0]     csr_write_data
);

   localparam int P   = phys_lat(FRAC_BITS);
   localparam int LAT = 2 * P + 6;

   // configuration registers
   logic [RW-1:0] dt_over_dx_ff;
   logic [RW-1:0] dx_over_dt_ff;
   logic [GW-1:0] gamma_m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_over_dx_ff <= RST_DT_OVER_DX;
         dx_over_dt_ff <= RST_DX_OVER_DT;
         gamma_m1_ff   <= RST_GAMMA_M1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DT_OVER_DX: dt_over_dx_ff <= csr_write_data;
            CSR_DX_OVER_DT: dx_over_dt_ff <= csr_write_data;
            CSR_GAMMA_M1:   gamma_m1_ff   <= csr_write_data[GW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // input register
   logic     t0_vld_ff;
   word_type ul_ff [3];
   word_type ur_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff <= 1'b0;
      end else begin
         t0_vld_ff <= start & ~busy;
      end
      ul_ff[0] <= req_left_density;
      ul_ff[1] <= req_left_momentum;
      ul_ff[2] <= req_left_energy;
      ur_ff[0] <= req_right_density;
      ur_ff[1] <= req_right_momentum;
      ur_ff[2] <= req_right_energy;
   end

   // left and right physical fluxes
   logic     pl_vld, pr_vld, pl_bad, pr_bad;
   word_type fl [3];
   word_type fr [3];

   ffe_phys #(.FRAC_BITS(FRAC_BITS)) u_phys_left (
      .clock, .reset, .in_valid(t0_vld_ff),
      .rho(ul_ff[0]), .mom(ul_ff[1]), .ene(ul_ff[2]), .gm1(gamma_m1_ff),
      .out_valid(pl_vld), .f_mass(fl[0]), .f_mom(fl[1]), .f_ene(fl[2]),
      .out_bad(pl_bad)
   );

   ffe_phys #(.FRAC_BITS(FRAC_BITS)) u_phys_right (
      .clock, .reset, .in_valid(t0_vld_ff),
      .rho(ur_ff[0]), .mom(ur_ff[1]), .ene(ur_ff[2]), .gm1(gamma_m1_ff),
      .out_valid(pr_vld), .f_mass(fr[0]), .f_mom(fr[1]), .f_ene(fr[2]),
      .out_bad(pr_bad)
   );

   // states held alongside the flux units
   logic [6*DW-1:0] u_dly;
   word_type        uld [3];
   word_type        urd [3];

   ffe_delay #(.WIDTH(6*DW), .DEPTH(P)) u_state_dly (
      .clock,
      .din({ul_ff[0], ul_ff[1], ul_ff[2], ur_ff[0], ur_ff[1], ur_ff[2]}),
      .dout(u_dly)
   );

   assign {uld[0], uld[1], uld[2], urd[0], urd[1], urd[2]} = u_dly;

   // D1: differences and exact sums
   logic              d1_vld_ff, d1_bad_ff;
   word_type          dfl_ff [3];
   word_type          dul_ff [3];
   logic signed [DW:0] s_ff  [3];
   logic signed [DW:0] fs1_ff [3];
   // D2: products
   logic               d2_vld_ff, d2_bad_ff;
   logic signed [2*DW-1:0] cp_ff [3];
   logic signed [2*DW-1:0] xp_ff [3];
   logic signed [DW:0] s2_ff  [3];
   logic signed [DW:0] fs2_ff [3];
   // D3: rescaled products
   logic               d3_vld_ff, d3_bad_ff;
   word_type           corr_ff [3];
   word_type           diss_ff [3];
   logic signed [DW:0] s3_ff  [3];
   logic signed [DW:0] fs3_ff [3];
   // D4: predictor and Lax-Friedrichs terms
   logic               d4_vld_ff, d4_bad_ff;
   word_type           us_ff [3];
   word_type           lf_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
         d3_vld_ff <= 1'b0;
         d4_vld_ff <= 1'b0;
      end else begin
         d1_vld_ff <= pl_vld;
         d2_vld_ff <= d1_vld_ff;
         d3_vld_ff <= d2_vld_ff;
         d4_vld_ff <= d3_vld_ff;
      end
      d1_bad_ff <= pl_bad | pr_bad;
      d2_bad_ff <= d1_bad_ff;
      d3_bad_ff <= d2_bad_ff;
      d4_bad_ff <= d3_bad_ff;
      for (int k = 0; k < 3; k++) begin
         dfl_ff[k]  <= sat32(WW'(fr[k]) - WW'(fl[k]));
         dul_ff[k]  <= sat32(WW'(uld[k]) - WW'(urd[k]));
         s_ff[k]    <= (DW+1)'(uld[k]) + (DW+1)'(urd[k]);
         fs1_ff[k]  <= (DW+1)'(fl[k]) + (DW+1)'(fr[k]);
         cp_ff[k]   <= $signed({1'b0, dt_over_dx_ff}) * dfl_ff[k];
         xp_ff[k]   <= $signed({1'b0, dx_over_dt_ff}) * dul_ff[k];
         s2_ff[k]   <= s_ff[k];
         fs2_ff[k]  <= fs1_ff[k];
         corr_ff[k] <= qshift(cp_ff[k], FRAC_BITS);
         diss_ff[k] <= qshift(xp_ff[k], FRAC_BITS);
         s3_ff[k]   <= s2_ff[k];
         fs3_ff[k]  <= fs2_ff[k];
         us_ff[k]   <= sat32((WW'(s3_ff[k]) - WW'(corr_ff[k])) >>> 1);
         lf_ff[k]   <= sat32((WW'(diss_ff[k]) + WW'(fs3_ff[k])) >>> 1);
      end
   end

   // Richtmyer flux of the predictor state
   logic     ps_vld, ps_bad;
   word_type fst [3];

   ffe_phys #(.FRAC_BITS(FRAC_BITS)) u_phys_star (
      .clock, .reset, .in_valid(d4_vld_ff),
      .rho(us_ff[0]), .mom(us_ff[1]), .ene(us_ff[2]), .gm1(gamma_m1_ff),
      .out_valid(ps_vld), .f_mass(fst[0]), .f_mom(fst[1]), .f_ene(fst[2]),
      .out_bad(ps_bad)
   );

   logic [3*DW:0] lf_dly;
   word_type      lfd [3];
   logic          bad_d;

   ffe_delay #(.WIDTH(3*DW+1), .DEPTH(P)) u_lf_dly (
      .clock,
      .din({lf_ff[0], lf_ff[1], lf_ff[2], d4_bad_ff}),
      .dout(lf_dly)
   );

   assign {lfd[0], lfd[1], lfd[2], bad_d} = lf_dly;

   // output register: FORCE average
   logic     out_vld_ff, out_bad_ff;
   word_type force_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= ps_vld;
      end
      out_bad_ff <= bad_d | ps_bad;
      for (int k = 0; k < 3; k++) begin
         force_ff[k] <= sat32((WW'(lfd[k]) + WW'(fst[k])) >>> 1);
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_mass_flux     = force_ff[0];
   assign rsp_momentum_flux = force_ff[1];
   assign rsp_energy_flux   = force_ff[2];
   assign rsp_invalid       = out_bad_ff;

   // checks
   a_lr_aligned: assert property (@(posedge clock) disable iff (reset)
      pl_vld == pr_vld)
      else $error("left and right flux units out of step");

   a_star_latency: assert property (@(posedge clock) disable iff (reset)
      ps_vld |-> $past(d4_vld_ff, P))
      else $error("predictor flux valid without matching entry");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result strobe without an accepted item");

endmodule
